### hdl/pps_pkg.sv
package pps_pkg;

    // Table geometry
    localparam int MAX_PROCS = 16;
    localparam int PROC_W    = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W     = $clog2(MAX_PROCS + 1);

    // Field widths
    localparam int SLOT_W = 4;
    localparam int PRIO_W = 8;
    localparam int TICK_W = 16;
    localparam int TIME_W = 20;

    localparam logic [TIME_W-1:0] CLOCK_MAX = {TIME_W{1'b1}};

    // Request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;

    // One process table entry
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic [TICK_W-1:0] arrival;
        logic [TICK_W-1:0] burst;
        logic [TICK_W-1:0] remaining;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

### hdl/preemptive_priority_scheduler_unit.sv
// Preemptive priority scheduler. A table of MAX_PROCS process slots lives in one
// single-port-read RAM with a live bit per slot held in flip-flops, so clear and
// reset empty the table at once. Load, clear and no-op words are answered
// straight from idle. A tick word scans every slot through one shared
// comparator, one slot per cycle as the RAM read port delivers it, then writes
// back the served slot in the update state and forms the result in the finish
// state. A new word is taken once the scheduler is back in idle and the result
// register is free or being drained.
module preemptive_priority_scheduler_unit
    import pps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  logic [1:0]        req_type,
    input  logic [SLOT_W-1:0] slot,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [TICK_W-1:0] arrival,
    input  logic [TICK_W-1:0] burst,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output logic [TIME_W-1:0] time_now,
    output logic [SLOT_W-1:0] running_slot,
    output logic              idle,
    output logic              finished,
    output logic [TIME_W-1:0] turnaround,
    output logic [TIME_W-1:0] waiting,
    output logic              all_done
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_UPD  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 pend_reg, pend_next;
    logic [PROC_W-1:0]    pidx_reg, pidx_next;
    logic                 found_reg, found_next;
    logic [PROC_W-1:0]    best_reg, best_next;
    entry_t               best_e_reg, best_e_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [TIME_W-1:0]    clock_reg, clock_next;
    logic [MAX_PROCS-1:0] live_reg, live_next;
    logic                 fin_reg, fin_next;
    logic [TIME_W-1:0]    tat_reg, tat_next;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic [TIME_W-1:0]    time_now_reg, time_now_next;
    logic [SLOT_W-1:0]    running_slot_reg, running_slot_next;
    logic                 idle_reg, idle_next;
    logic                 finished_reg, finished_next;
    logic [TIME_W-1:0]    turnaround_reg, turnaround_next;
    logic [TIME_W-1:0]    waiting_reg, waiting_next;
    logic                 all_done_reg, all_done_next;

    logic                 ram_we;
    logic [PROC_W-1:0]    ram_waddr;
    entry_t               ram_wdata;
    logic [PROC_W-1:0]    ram_raddr;
    entry_t               ram_rdata;

    logic                 accept;
    logic                 out_free;
    logic                 emit_imm;
    logic [PROC_W-1:0]    slot_idx;
    logic                 cand_ok;
    logic                 cand_better;
    logic [TICK_W-1:0]    rem_dec;
    logic [TIME_W-1:0]    clk_inc;
    logic [TIME_W-1:0]    burst_ext;

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_PROCS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = req_valid && req_ready;
    assign slot_idx  = PROC_W'(slot);
    assign ram_raddr = cnt_reg[PROC_W-1:0];

    // Shared comparator: slot read last cycle against current best
    assign cand_ok = pend_reg && live_reg[pidx_reg] &&
                     (TIME_W'(ram_rdata.arrival) <= now_reg);
    assign cand_better = !found_reg ||
                         (ram_rdata.prio < best_e_reg.prio) ||
                         ((ram_rdata.prio == best_e_reg.prio) &&
                          (ram_rdata.arrival < best_e_reg.arrival));

    assign rem_dec   = best_e_reg.remaining - TICK_W'(1);
    assign clk_inc   = (clock_reg == CLOCK_MAX) ? CLOCK_MAX : clock_reg + TIME_W'(1);
    assign burst_ext = TIME_W'(best_e_reg.burst);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        cnt_next          = cnt_reg;
        pend_next         = pend_reg;
        pidx_next         = pidx_reg;
        found_next        = found_reg;
        best_next         = best_reg;
        best_e_next       = best_e_reg;
        now_next          = now_reg;
        clock_next        = clock_reg;
        live_next         = live_reg;
        fin_next          = fin_reg;
        tat_next          = tat_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp_ready;
        time_now_next     = time_now_reg;
        running_slot_next = running_slot_reg;
        idle_next         = idle_reg;
        finished_next     = finished_reg;
        turnaround_next   = turnaround_reg;
        waiting_next      = waiting_reg;
        all_done_next     = all_done_reg;
        ram_we            = 1'b0;
        ram_waddr         = best_reg;
        ram_wdata         = best_e_reg;
        emit_imm          = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_LOAD:
                        begin
                            emit_imm = 1'b1;
                            if (32'(slot) < MAX_PROCS)
                            begin
                                ram_we              = 1'b1;
                                ram_waddr           = slot_idx;
                                ram_wdata.prio      = priority_req;
                                ram_wdata.arrival   = arrival;
                                ram_wdata.burst     = burst;
                                ram_wdata.remaining = burst;
                                live_next[slot_idx] = (burst != '0);
                            end
                        end
                        REQ_CLEAR:
                        begin
                            emit_imm   = 1'b1;
                            live_next  = '0;
                            clock_next = '0;
                        end
                        REQ_TICK:
                        begin
                            state_next = ST_SCAN;
                            cnt_next   = '0;
                            pend_next  = 1'b0;
                            found_next = 1'b0;
                            now_next   = clock_reg;
                        end
                        default:
                        begin
                            emit_imm = 1'b1;
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (cand_ok && cand_better)
                begin
                    found_next  = 1'b1;
                    best_next   = pidx_reg;
                    best_e_next = ram_rdata;
                end
                if (cnt_reg == CNT_W'(MAX_PROCS))
                begin
                    pend_next  = 1'b0;
                    state_next = ST_UPD;
                end
                else
                begin
                    pend_next = 1'b1;
                    pidx_next = cnt_reg[PROC_W-1:0];
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
            end
            ST_UPD:
            begin
                clock_next = clk_inc;
                fin_next   = found_reg && (rem_dec == '0);
                tat_next   = clk_inc - TIME_W'(best_e_reg.arrival);
                if (found_reg)
                begin
                    ram_we              = 1'b1;
                    ram_wdata.remaining = rem_dec;
                    live_next[best_reg] = (rem_dec != '0);
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    rsp_valid_next    = 1'b1;
                    time_now_next     = now_reg;
                    running_slot_next = found_reg ? SLOT_W'(best_reg) : '0;
                    idle_next         = !found_reg;
                    finished_next     = fin_reg;
                    turnaround_next   = fin_reg ? tat_reg : '0;
                    waiting_next      = (fin_reg && (tat_reg >= burst_ext)) ?
                                        tat_reg - burst_ext : '0;
                    all_done_next     = ~|live_reg;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Load, clear and no-op words report right away
        if (emit_imm)
        begin
            rsp_valid_next    = 1'b1;
            time_now_next     = clock_reg;
            running_slot_next = '0;
            idle_next         = 1'b1;
            finished_next     = 1'b0;
            turnaround_next   = '0;
            waiting_next      = '0;
            all_done_next     = ~|live_next;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            clock_reg     <= '0;
            live_reg      <= '0;
            fin_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            clock_reg     <= clock_next;
            live_reg      <= live_next;
            fin_reg       <= fin_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        pidx_reg         <= pidx_next;
        best_reg         <= best_next;
        best_e_reg       <= best_e_next;
        now_reg          <= now_next;
        tat_reg          <= tat_next;
        time_now_reg     <= time_now_next;
        running_slot_reg <= running_slot_next;
        idle_reg         <= idle_next;
        finished_reg     <= finished_next;
        turnaround_reg   <= turnaround_next;
        waiting_reg      <= waiting_next;
        all_done_reg     <= all_done_next;
    end

    assign rsp_valid    = rsp_valid_reg;
    assign time_now     = time_now_reg;
    assign running_slot = running_slot_reg;
    assign idle         = idle_reg;
    assign finished     = finished_reg;
    assign turnaround   = turnaround_reg;
    assign waiting      = waiting_reg;
    assign all_done     = all_done_reg;

    // Checks
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (req_type == REQ_CLEAR) |=> (live_reg == '0) && (clock_reg == '0))
        else $error("clear did not empty table");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (cnt_reg <= CNT_W'(MAX_PROCS)))
        else $error("scan counter overran table");

    a_idle_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(idle_reg && finished_reg))
        else $error("idle word reports completion");

    a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && finished_reg |-> (waiting_reg <= turnaround_reg))
        else $error("waiting exceeds turnaround");

    a_upd_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD) |-> ($past(state_reg) == ST_SCAN))
        else $error("update entered without scan");

endmodule

### hdl/pps_ram.sv
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### bench/pps_checker.sv
module pps_checker
    import pps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  logic              req_ready,
    input  logic [1:0]        req_type,
    input  logic [SLOT_W-1:0] slot,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic [TICK_W-1:0] arrival,
    input  logic [TICK_W-1:0] burst,
    input  logic              rsp_valid,
    input  logic              rsp_ready,
    input  logic [TIME_W-1:0] time_now,
    input  logic [SLOT_W-1:0] running_slot,
    input  logic              idle,
    input  logic              finished,
    input  logic [TIME_W-1:0] turnaround,
    input  logic [TIME_W-1:0] waiting,
    input  logic              all_done,
    output int                mismatches,
    output int                backlog
);

    // One result word as the scheduler reports it
    typedef struct packed {
        logic [TIME_W-1:0] time_now;
        logic [SLOT_W-1:0] running_slot;
        logic              idle;
        logic              finished;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] waiting;
        logic              all_done;
    } sched_word_t;

    // Shadow of the process table and the scheduler clock
    entry_t            proc_table [MAX_PROCS];
    logic [TIME_W-1:0] sched_clock;
    sched_word_t       expected_words [$];

    task automatic report_mismatch(input string field, input logic [TIME_W-1:0] got,
                                   input logic [TIME_W-1:0] want);
        $display("mismatch @%0t: %s got 0x%0h, expected 0x%0h", $time, field, got, want);
        mismatches++;
    endtask

    // Apply one accepted request word to the shadow table, queue its result
    task automatic predict_schedule();
        sched_word_t       want;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] span;
        int                pick;
        bit                found;
        now   = sched_clock;
        want  = '0;
        want.time_now = now;
        want.idle     = 1'b1;
        pick  = 0;
        found = 1'b0;
        case (req_type)
            REQ_LOAD: begin
                proc_table[slot].prio      = priority_req;
                proc_table[slot].arrival   = arrival;
                proc_table[slot].burst     = burst;
                proc_table[slot].remaining = burst;
            end
            REQ_CLEAR: begin
                for (int k = 0; k < MAX_PROCS; k++)
                    proc_table[k].remaining = '0;
                sched_clock = '0;
            end
            REQ_TICK: begin
                // smallest priority, then earliest arrival, then lowest slot
                for (int k = 0; k < MAX_PROCS; k++)
                begin
                    if (proc_table[k].remaining != '0 && proc_table[k].arrival <= now)
                    begin
                        if (!found || proc_table[k].prio < proc_table[pick].prio ||
                            (proc_table[k].prio == proc_table[pick].prio &&
                             proc_table[k].arrival < proc_table[pick].arrival))
                        begin
                            found = 1'b1;
                            pick  = k;
                        end
                    end
                end
                sched_clock = (now == CLOCK_MAX) ? now : now + 1'b1;
                if (found)
                begin
                    want.idle         = 1'b0;
                    want.running_slot = pick[SLOT_W-1:0];
                    proc_table[pick].remaining = proc_table[pick].remaining - 1'b1;
                    if (proc_table[pick].remaining == '0)
                    begin
                        span = sched_clock - {{(TIME_W-TICK_W){1'b0}}, proc_table[pick].arrival};
                        want.finished   = 1'b1;
                        want.turnaround = span;
                        // only a saturated clock can push waiting below zero
                        want.waiting = (span >= proc_table[pick].burst) ?
                                       span - proc_table[pick].burst : '0;
                    end
                end
            end
            default: ;
        endcase
        want.all_done = 1'b1;
        for (int k = 0; k < MAX_PROCS; k++)
            if (proc_table[k].remaining != '0)
                want.all_done = 1'b0;
        expected_words.push_back(want);
    endtask

    // Compare one accepted result word with the oldest expectation
    task automatic check_word();
        sched_word_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch("result word with none expected", '0, '0);
            return;
        end
        want = expected_words.pop_front();
        if (time_now !== want.time_now)
            report_mismatch("time_now", time_now, want.time_now);
        if (running_slot !== want.running_slot)
            report_mismatch("running_slot", running_slot, want.running_slot);
        if (idle !== want.idle)
            report_mismatch("idle", idle, want.idle);
        if (finished !== want.finished)
            report_mismatch("finished", finished, want.finished);
        if (turnaround !== want.turnaround)
            report_mismatch("turnaround", turnaround, want.turnaround);
        if (waiting !== want.waiting)
            report_mismatch("waiting", waiting, want.waiting);
        if (all_done !== want.all_done)
            report_mismatch("all_done", all_done, want.all_done);
    endtask

    // Watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            for (int k = 0; k < MAX_PROCS; k++)
                proc_table[k] = '0;
            sched_clock = '0;
            mismatches  = 0;
            backlog    <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
                check_word();
            if (req_valid && req_ready)
                predict_schedule();
            backlog <= expected_words.size();
        end
    end

endmodule

### bench/tb_preemptive_priority_scheduler_unit.sv
module tb_preemptive_priority_scheduler_unit;
    import pps_pkg::*;

    localparam logic [1:0] REQ_NOP = 2'd3;
    localparam int ITEM_TARGET  = 1950;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 40;
    localparam int HOLD_AT_WORD = 600;
    localparam int HOLD_CYCLES  = 400;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              req_valid;
    logic              req_ready;
    logic [1:0]        req_type;
    logic [SLOT_W-1:0] slot;
    logic [PRIO_W-1:0] priority_req;
    logic [TICK_W-1:0] arrival;
    logic [TICK_W-1:0] burst;
    logic              rsp_valid;
    logic              rsp_ready;
    logic [TIME_W-1:0] time_now;
    logic [SLOT_W-1:0] running_slot;
    logic              idle;
    logic              finished;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;

    int mismatches;
    int backlog;
    int cycles = 0;
    int sent_count = 0;
    int words_left = 0;
    int sched_now = 0;

    preemptive_priority_scheduler_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .slot         (slot),
        .priority_req (priority_req),
        .arrival      (arrival),
        .burst        (burst),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .time_now     (time_now),
        .running_slot (running_slot),
        .idle         (idle),
        .finished     (finished),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .all_done     (all_done)
    );

    pps_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_ready    (req_ready),
        .req_type     (req_type),
        .slot         (slot),
        .priority_req (priority_req),
        .arrival      (arrival),
        .burst        (burst),
        .rsp_valid    (rsp_valid),
        .rsp_ready    (rsp_ready),
        .time_now     (time_now),
        .running_slot (running_slot),
        .idle         (idle),
        .finished     (finished),
        .turnaround   (turnaround),
        .waiting      (waiting),
        .all_done     (all_done),
        .mismatches   (mismatches),
        .backlog      (backlog)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // Offer one request word; the sender may idle between bursts of words
    task automatic send_word(input logic [1:0] kind, input logic [SLOT_W-1:0] s,
                             input logic [PRIO_W-1:0] p, input logic [TICK_W-1:0] a,
                             input logic [TICK_W-1:0] b);
        int gap;
        if (words_left == 0)
        begin
            words_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        words_left--;
        req_valid    <= 1'b1;
        req_type     <= kind;
        slot         <= s;
        priority_req <= p;
        arrival      <= a;
        burst        <= b;
        @(posedge clk);
        while (!req_ready) @(posedge clk);
        sent_count++;
        if (kind == REQ_TICK)
            sched_now++;
        else if (kind == REQ_CLEAR)
            sched_now = 0;
    endtask

    // Tick, clear and no-op words carry random junk in the unused fields
    task automatic send_bare(input logic [1:0] kind);
        send_word(kind, SLOT_W'($urandom_range(0, 15)), PRIO_W'($urandom_range(0, 255)),
                  TICK_W'($urandom_range(0, 65535)), TICK_W'($urandom_range(0, 65535)));
    endtask

    task automatic pause_until_drained();
        req_valid <= 1'b0;
        words_left = 0;
        @(posedge clk);
        while (backlog != 0) @(posedge clk);
    endtask

    // Load a process that arrives a few ticks from now; returns its burst
    task automatic load_near(output int b);
        int a;
        a = sched_now + $urandom_range(0, 12);
        if (a > 65535)
            a = 65535;
        b = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 6);
        send_word(REQ_LOAD, SLOT_W'($urandom_range(0, 15)),
                  PRIO_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                      : $urandom_range(0, 7)),
                  TICK_W'(a), TICK_W'(b));
    endtask

    // Well-formed round: mostly clear, load a few processes, tick them through
    task automatic run_schedule_round();
        int nproc;
        int ticks_left;
        int b;
        if ($urandom_range(0, 9) < 7)
            send_bare(REQ_CLEAR);
        nproc      = $urandom_range(1, 6);
        ticks_left = 13 + $urandom_range(0, 3);
        repeat (nproc)
        begin
            load_near(b);
            ticks_left += b;
        end
        while (ticks_left > 0)
        begin
            // late arrival that may preempt or overwrite a live slot
            if ($urandom_range(0, 7) == 0)
            begin
                load_near(b);
                ticks_left += b;
            end
            send_bare(REQ_TICK);
            ticks_left--;
        end
    endtask

    // Noise: any request code, fields often full-range
    task automatic run_noise();
        repeat ($urandom_range(1, 8))
        begin
            send_word(2'($urandom_range(0, 3)), SLOT_W'($urandom_range(0, 15)),
                      PRIO_W'($urandom_range(0, 255)),
                      TICK_W'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 8)),
                      TICK_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                          : $urandom_range(0, 8)));
        end
    endtask

    // Response side: changing stall patterns, one long hold-off
    initial
    begin
        int mode;
        int span;
        bit held;
        held = 1'b0;
        rsp_ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(posedge clk);
                if (!held && sent_count >= HOLD_AT_WORD)
                begin
                    held = 1'b1;
                    rsp_ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0: rsp_ready <= 1'b1;
                    1: rsp_ready <= ($urandom_range(0, 1) == 1);
                    2: rsp_ready <= ($urandom_range(0, 3) == 0);
                    default: rsp_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        req_valid    <= 1'b0;
        req_type     <= REQ_NOP;
        slot         <= '0;
        priority_req <= '0;
        arrival      <= '0;
        burst        <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty table: idle tick, no-op, clear
        send_bare(REQ_TICK);
        send_bare(REQ_NOP);
        send_bare(REQ_CLEAR);
        // worst priority, a process that never arrives, a zero burst
        send_word(REQ_LOAD, 4'd0, 8'd255, 16'd0, 16'd1);
        send_word(REQ_LOAD, 4'd15, 8'd0, 16'hFFFF, 16'hFFFF);
        send_word(REQ_LOAD, 4'd9, 8'd0, 16'd0, 16'd0);
        // equal priority and arrival: lower slot first
        send_word(REQ_LOAD, 4'd5, 8'd0, 16'd0, 16'd2);
        send_word(REQ_LOAD, 4'd3, 8'd0, 16'd0, 16'd2);
        // equal priority: earlier arrival beats lower slot
        send_word(REQ_LOAD, 4'd12, 8'd1, 16'd0, 16'd1);
        send_word(REQ_LOAD, 4'd1, 8'd1, 16'd2, 16'd1);
        send_bare(REQ_TICK);
        send_bare(REQ_TICK);
        // reload a live slot
        send_word(REQ_LOAD, 4'd5, 8'd0, 16'd1, 16'd1);
        repeat (5) send_bare(REQ_TICK);
        send_bare(REQ_CLEAR);
        pause_until_drained();

        // random part
        while (sent_count < ITEM_TARGET)
        begin
            case ($urandom_range(0, 9))
                7, 8: run_noise();
                9:
                begin
                    pause_until_drained();
                    run_schedule_round();
                end
                default: run_schedule_round();
            endcase
        end

        pause_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && backlog == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
